[sv/rstc_pkg.sv]
`timescale 1ns / 1ps

package rstc_pkg;

  localparam logic [1:0] INTERNAL_TICKS = 2'd3;
  localparam logic [1:0] SAMPLE_TICKS   = 2'd2;
  localparam logic [2:0] RELEASE_TICKS  = 3'd6;

  localparam logic [31:0] KEY_VALUE = 32'ha500_0000;
  localparam logic [31:0] KEY_MASK  = 32'hff00_0000;
  localparam logic [20:0] MR_MASK   = 21'h10_0f17;
  localparam logic [20:0] MR_RESET  = 21'h00_0001;

  localparam int unsigned MR_URSTEN    = 0;
  localparam int unsigned MR_URSTASYNC = 2;
  localparam int unsigned MR_URSTIEN   = 4;
  localparam int unsigned MR_ENGCLR    = 20;

  localparam logic [3:0] OP_READ      = 4'd0;
  localparam logic [3:0] OP_WRITE     = 4'd1;
  localparam logic [3:0] OP_PIN       = 4'd2;
  localparam logic [3:0] OP_POWER     = 4'd3;
  localparam logic [3:0] OP_WATCHDOG  = 4'd4;
  localparam logic [3:0] OP_TICK      = 4'd5;
  localparam logic [3:0] OP_COLD      = 4'd6;
  localparam logic [3:0] OP_WAKEUP    = 4'd7;
  localparam logic [3:0] OP_TAKE_WARM = 4'd8;

  localparam logic [3:0] ADDR_CTRL   = 4'd0;
  localparam logic [3:0] ADDR_STATUS = 4'd4;
  localparam logic [3:0] ADDR_MODE   = 4'd8;

  typedef enum logic [2:0] {
    RT_GENERAL  = 3'd0,
    RT_BACKUP   = 3'd1,
    RT_WATCHDOG = 3'd2,
    RT_SOFTWARE = 3'd3,
    RT_USER     = 3'd4,
    RT_NONE     = 3'd7
  } rst_type_e;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  addr;
    logic [31:0] wdata;
    logic        level;
    logic        write_protected;
    logic        system_in_reset;
  } rc_in_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic        ext_rst_n;
    logic        core_reset_request;
    logic        system_reset_pulse;
    logic        warm_taken;
    logic        gpbr_clear;
  } rc_out_t;

  typedef struct packed {
    logic [20:0] mode;
    logic [2:0]  last_type;
    rst_type_e   pending;
    logic        user_status;
    logic        sw_busy;
    logic        sw_proc;
    logic        pin;
    logic        power;
    logic        user_active;
    logic        ext_out;
    logic        core_req;
    logic        warm;
    logic [16:0] ext_cnt;
    logic [1:0]  samp_cnt;
    logic [1:0]  int_cnt;
    logic [2:0]  rel_cnt;
    logic        pulse;
  } rc_state_t;

  localparam rc_state_t STATE_RESET = '{
    mode:        MR_RESET,
    last_type:   3'd0,
    pending:     RT_NONE,
    user_status: 1'b1,
    sw_busy:     1'b0,
    sw_proc:     1'b0,
    pin:         1'b1,
    power:       1'b0,
    user_active: 1'b0,
    ext_out:     1'b1,
    core_req:    1'b0,
    warm:        1'b0,
    ext_cnt:     17'd0,
    samp_cnt:    2'd0,
    int_cnt:     2'd0,
    rel_cnt:     3'd0,
    pulse:       1'b0
  };

endpackage

[sv/reset_controller_unit.sv]
`timescale 1ns / 1ps

// channel  | signals                              | beat when
// ---------+--------------------------------------+--------------------------
// in       | in_valid_i, in_stall_o, in_data_i    | in_valid_i & !in_stall_o
// out      | out_valid_o, out_stall_i, out_data_o | out_valid_o & !out_stall_i
// cfg      | cfg_valid_i, cfg_ready_o, cfg_data_i | cfg_valid_i & cfg_ready_o
//
// one beat per cycle sustained while out_stall_i is low; an input beat goes
// to the input register, then its state update into the result register
// rst_ni clears the state to the cold-reset values and empties both registers
// in_stall_o rises only when the input register is full and the result
// register is held by out_stall_i

module reset_controller_unit
  import rstc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  rc_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output rc_out_t out_data_o,
  input  logic    cfg_valid_i,
  output logic    cfg_ready_o,
  input  logic    cfg_data_i
);

  logic      in_valid_q;
  rc_in_t    in_q;
  logic      out_valid_q;
  rc_out_t   out_q;
  rc_out_t   out_d;
  rc_state_t st_q;
  rc_state_t st_d;
  logic      gen_backup_q;
  logic      fire;
  logic      in_take;

  function automatic rc_state_t f_assert_ext(rc_state_t s);
    rc_state_t r;
    r = s;
    r.ext_out = 1'b0;
    r.ext_cnt = 17'd1 << ({1'b0, s.mode[11:8]} + 5'd1);
    return r;
  endfunction

  function automatic rc_state_t f_request(rc_state_t s);
    rc_state_t r;
    r = s;
    r.core_req = 1'b1;
    r.warm     = 1'b1;
    r.pulse    = 1'b1;
    return r;
  endfunction

  function automatic rc_state_t f_user_event(rc_state_t s);
    rc_state_t r;
    r = s;
    if (s.mode[MR_URSTEN] && !s.power && !s.user_active && s.pending == RT_NONE) begin
      r.pending     = RT_USER;
      r.user_active = 1'b1;
      r = f_assert_ext(r);
      r = f_request(r);
    end
    return r;
  endfunction

  function automatic rc_state_t f_internal_done(rc_state_t s);
    rc_state_t r;
    logic      proc;
    r = s;
    proc = (s.pending == RT_WATCHDOG) || (s.pending == RT_SOFTWARE && s.sw_proc);
    r.sw_busy = 1'b0;
    r.sw_proc = 1'b0;
    r.warm    = 1'b0;
    if (proc) begin
      if (!s.pin && !s.power && s.mode[MR_URSTEN]) begin
        r.pending     = RT_USER;
        r.user_active = 1'b1;
        r = f_assert_ext(r);
      end else begin
        r.last_type = s.pending;
        r.pending   = RT_NONE;
        r.core_req  = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic rc_state_t f_clear_active(rc_state_t s);
    rc_state_t r;
    r = s;
    r.samp_cnt    = 2'd0;
    r.int_cnt     = 2'd0;
    r.rel_cnt     = 3'd0;
    r.pending     = RT_NONE;
    r.sw_busy     = 1'b0;
    r.sw_proc     = 1'b0;
    r.user_active = 1'b0;
    r.core_req    = 1'b0;
    r.warm        = 1'b0;
    return r;
  endfunction

  assign fire        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !fire;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    rc_state_t s;
    logic [31:0] rdata;
    logic [2:0]  t;
    logic        taken;
    logic        active;
    s     = st_q;
    rdata = 32'd0;
    taken = 1'b0;
    t     = 3'd0;
    active = 1'b0;
    s.pulse = 1'b0;
    case (in_q.op)
      OP_READ: begin
        if (in_q.addr == ADDR_MODE) begin
          rdata = {11'd0, s.mode};
        end else if (in_q.addr == ADDR_STATUS) begin
          t = s.last_type;
          if (t == RT_GENERAL && gen_backup_q) begin
            t = RT_BACKUP;
          end
          rdata = {14'd0, s.sw_busy, s.pin && !s.power, 5'd0, t, 7'd0, s.user_status};
          s.user_status = 1'b0;
        end
      end
      OP_WRITE: begin
        if (in_q.addr == ADDR_CTRL) begin
          if ((in_q.wdata & KEY_MASK) == KEY_VALUE && !s.sw_busy && s.pending == RT_NONE
              && (in_q.wdata[0] || in_q.wdata[3])) begin
            s.sw_busy = 1'b1;
            s.sw_proc = in_q.wdata[0];
            s.int_cnt = INTERNAL_TICKS;
            if (in_q.wdata[3]) begin
              s = f_assert_ext(s);
            end
            if (in_q.wdata[0]) begin
              s.pending = RT_SOFTWARE;
              s = f_request(s);
            end
          end
        end else if (in_q.addr == ADDR_MODE) begin
          if ((in_q.wdata & KEY_MASK) == KEY_VALUE && !in_q.write_protected) begin
            s.mode = in_q.wdata[20:0] & MR_MASK;
          end
        end
      end
      OP_PIN: begin
        s.pin = in_q.level;
        if (st_q.pin && !in_q.level) begin
          s.user_status = 1'b1;
          if (s.user_active) begin
            s.rel_cnt = 3'd0;
          end else if (s.mode[MR_URSTASYNC]) begin
            s = f_user_event(s);
          end else begin
            s.samp_cnt = SAMPLE_TICKS;
          end
        end else if (!st_q.pin && in_q.level) begin
          s.samp_cnt = 2'd0;
          if (!s.power && s.pending == RT_BACKUP) begin
            s = f_request(s);
          end else if (s.user_active && s.pending == RT_USER) begin
            s.rel_cnt = RELEASE_TICKS;
          end
        end
      end
      OP_POWER: begin
        if (s.power != in_q.level) begin
          s.power = in_q.level;
          if (in_q.level) begin
            s.int_cnt     = 2'd0;
            s.rel_cnt     = 3'd0;
            s.sw_busy     = 1'b0;
            s.sw_proc     = 1'b0;
            s.user_active = 1'b0;
            s.user_status = 1'b1;
            s.pending     = RT_BACKUP;
            s = f_assert_ext(s);
          end else if (s.pin && s.pending == RT_BACKUP && !in_q.system_in_reset) begin
            s = f_request(s);
          end
        end
      end
      OP_WATCHDOG: begin
        if (in_q.level) begin
          if (s.pending != RT_BACKUP && s.pending != RT_USER) begin
            s.rel_cnt     = 3'd0;
            s.sw_busy     = 1'b0;
            s.sw_proc     = 1'b0;
            s.user_active = 1'b0;
            s.pending     = RT_WATCHDOG;
            s = f_assert_ext(s);
            s.core_req    = 1'b1;
            s.warm        = 1'b1;
            s.int_cnt     = INTERNAL_TICKS;
          end
        end else if (s.pending == RT_WATCHDOG && !in_q.system_in_reset) begin
          s.pending  = RT_NONE;
          s.warm     = 1'b0;
          s.int_cnt  = 2'd0;
          s.ext_cnt  = 17'd0;
          s.ext_out  = 1'b1;
          s.core_req = 1'b0;
        end
      end
      OP_TICK: begin
        if (s.ext_cnt != 17'd0) begin
          s.ext_cnt = s.ext_cnt - 17'd1;
          if (s.ext_cnt == 17'd0) begin
            s.ext_out = 1'b1;
          end
        end
        if (s.samp_cnt != 2'd0) begin
          s.samp_cnt = s.samp_cnt - 2'd1;
          if (s.samp_cnt == 2'd0 && !s.pin) begin
            s = f_user_event(s);
          end
        end
        if (s.int_cnt != 2'd0) begin
          s.int_cnt = s.int_cnt - 2'd1;
          if (s.int_cnt == 2'd0) begin
            s = f_internal_done(s);
          end
        end
        if (s.rel_cnt != 3'd0) begin
          s.rel_cnt = s.rel_cnt - 3'd1;
          if (s.rel_cnt == 3'd0 && s.user_active && s.pin && !s.power
              && s.pending == RT_USER) begin
            s.user_active = 1'b0;
            s.last_type   = RT_USER;
            s.pending     = RT_NONE;
            s.core_req    = 1'b0;
            s.warm        = 1'b0;
          end
        end
      end
      OP_COLD: begin
        s = STATE_RESET;
      end
      OP_WAKEUP: begin
        active = (s.pending == RT_SOFTWARE && s.sw_busy && s.sw_proc)
              || (s.pending == RT_WATCHDOG && s.int_cnt != 2'd0)
              || (s.pending == RT_USER && s.user_active)
              || (s.pending == RT_BACKUP && s.power);
        if (!active) begin
          if (s.pending != RT_NONE) begin
            s.last_type = s.pending;
          end
          s = f_clear_active(s);
        end
      end
      OP_TAKE_WARM: begin
        taken  = s.warm;
        s.warm = 1'b0;
      end
      default: begin
      end
    endcase
    st_d = s;
    out_d.rdata              = rdata;
    out_d.irq                = s.user_status && !s.mode[MR_URSTEN] && s.mode[MR_URSTIEN];
    out_d.ext_rst_n          = s.ext_out;
    out_d.core_reset_request = s.core_req;
    out_d.system_reset_pulse = s.pulse;
    out_d.warm_taken         = taken;
    out_d.gpbr_clear         = s.mode[MR_ENGCLR];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      st_q         <= STATE_RESET;
      gen_backup_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        gen_backup_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule

[bench/reset_controller_check.sv]
`timescale 1ns / 1ps

module reset_controller_check
  import rstc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_stall_i,
  input  rc_in_t  in_data_i,
  input  logic    out_valid_i,
  input  logic    out_stall_i,
  input  rc_out_t out_data_i,
  input  logic    cfg_valid_i,
  input  logic    cfg_ready_i,
  input  logic    cfg_data_i,
  output int      faults_o,
  output int      due_o
);

  localparam int unsigned CR_PROCRST = 0;
  localparam int unsigned CR_EXTRST  = 3;
  localparam int unsigned SR_USER    = 0;
  localparam int unsigned SR_NRSTL   = 16;
  localparam int unsigned SR_SRCMP   = 17;
  localparam int unsigned LOG_CAP    = 100;

  logic        backup_view;
  logic [20:0] mode_r;
  rst_type_e   last_r;
  rst_type_e   pend_r;
  logic        usr_stat, busy, sw_proc, pin, power, usr_act;
  logic        ext_lvl, core_req, warm, pulse;
  logic [16:0] ext_cnt;
  logic [1:0]  samp_cnt;
  logic [1:0]  int_cnt;
  logic [2:0]  rel_cnt;

  rc_out_t     lines_due[$];
  rc_out_t     want;
  int          fault_cnt = 0;

  task automatic log_fault(string msg);
    if (fault_cnt < LOG_CAP) $display("%0t ERROR %s", $time, msg);
    fault_cnt++;
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) log_fault($sformatf("%s expected %h got %h", name, want_v, got_v));
  endtask

  function automatic void drive_ext_reset();
    ext_lvl = 1'b0;
    ext_cnt = 17'd1 << (mode_r[11:8] + 5'd1);
  endfunction

  function automatic void raise_request();
    core_req = 1'b1;
    warm     = 1'b1;
    pulse    = 1'b1;
  endfunction

  function automatic void user_reset_event();
    if (!mode_r[MR_URSTEN] || power || usr_act || pend_r != RT_NONE) return;
    pend_r  = RT_USER;
    usr_act = 1'b1;
    drive_ext_reset();
    raise_request();
  endfunction

  function automatic logic resume_user();
    if (pin || power || !mode_r[MR_URSTEN]) return 1'b0;
    pend_r  = RT_USER;
    usr_act = 1'b1;
    drive_ext_reset();
    return 1'b1;
  endfunction

  function automatic void internal_expired();
    rst_type_e t;
    logic      proc;
    t       = pend_r;
    proc    = (t == RT_WATCHDOG) || (t == RT_SOFTWARE && sw_proc);
    busy    = 1'b0;
    sw_proc = 1'b0;
    warm    = 1'b0;
    if (proc && !resume_user()) begin
      last_r   = t;
      pend_r   = RT_NONE;
      core_req = 1'b0;
    end
  endfunction

  function automatic void release_expired();
    if (!usr_act || !pin || power || pend_r != RT_USER) return;
    usr_act  = 1'b0;
    last_r   = RT_USER;
    pend_r   = RT_NONE;
    core_req = 1'b0;
    warm     = 1'b0;
  endfunction

  function automatic void slow_tick();
    if (ext_cnt != 0) begin
      ext_cnt = ext_cnt - 1'b1;
      if (ext_cnt == 0) ext_lvl = 1'b1;
    end
    if (samp_cnt != 0) begin
      samp_cnt = samp_cnt - 1'b1;
      if (samp_cnt == 0 && !pin) user_reset_event();
    end
    if (int_cnt != 0) begin
      int_cnt = int_cnt - 1'b1;
      if (int_cnt == 0) internal_expired();
    end
    if (rel_cnt != 0) begin
      rel_cnt = rel_cnt - 1'b1;
      if (rel_cnt == 0) release_expired();
    end
  endfunction

  function automatic void pin_change(logic lv);
    logic was;
    was = pin;
    pin = lv;
    if (was && !lv) begin
      usr_stat = 1'b1;
      if (usr_act) rel_cnt = '0;
      else if (mode_r[MR_URSTASYNC]) user_reset_event();
      else samp_cnt = SAMPLE_TICKS;
    end else if (!was && lv) begin
      samp_cnt = '0;
      if (!power && pend_r == RT_BACKUP) raise_request();
      else if (usr_act && pend_r == RT_USER) rel_cnt = RELEASE_TICKS;
    end
  endfunction

  function automatic void power_change(logic lv, logic inr);
    if (power == lv) return;
    power = lv;
    if (lv) begin
      int_cnt  = '0;
      rel_cnt  = '0;
      busy     = 1'b0;
      sw_proc  = 1'b0;
      usr_act  = 1'b0;
      usr_stat = 1'b1;
      pend_r   = RT_BACKUP;
      drive_ext_reset();
    end else if (pin && pend_r == RT_BACKUP && !inr) begin
      raise_request();
    end
  endfunction

  function automatic void watchdog_change(logic lv, logic inr);
    if (lv) begin
      if (pend_r == RT_BACKUP || pend_r == RT_USER) return;
      rel_cnt  = '0;
      busy     = 1'b0;
      sw_proc  = 1'b0;
      usr_act  = 1'b0;
      pend_r   = RT_WATCHDOG;
      drive_ext_reset();
      core_req = 1'b1;
      warm     = 1'b1;
      int_cnt  = INTERNAL_TICKS;
    end else if (pend_r == RT_WATCHDOG && !inr) begin
      pend_r   = RT_NONE;
      warm     = 1'b0;
      int_cnt  = '0;
      ext_cnt  = '0;
      ext_lvl  = 1'b1;
      core_req = 1'b0;
    end
  endfunction

  function automatic void clear_activity();
    samp_cnt = '0;
    int_cnt  = '0;
    rel_cnt  = '0;
    pend_r   = RT_NONE;
    busy     = 1'b0;
    sw_proc  = 1'b0;
    usr_act  = 1'b0;
    core_req = 1'b0;
    warm     = 1'b0;
  endfunction

  function automatic void cold_restart();
    clear_activity();
    ext_cnt  = '0;
    last_r   = RT_GENERAL;
    mode_r   = MR_RESET;
    usr_stat = 1'b1;
    pin      = 1'b1;
    power    = 1'b0;
    ext_lvl  = 1'b1;
  endfunction

  function automatic void wakeup_restart();
    logic in_flight;
    in_flight = (pend_r == RT_SOFTWARE && busy && sw_proc) ||
                (pend_r == RT_WATCHDOG && int_cnt != 0) ||
                (pend_r == RT_USER && usr_act) ||
                (pend_r == RT_BACKUP && power);
    if (in_flight) return;
    if (pend_r != RT_NONE) last_r = pend_r;
    clear_activity();
  endfunction

  function automatic logic [31:0] read_reg(logic [3:0] addr);
    logic [31:0] v;
    logic [2:0]  t;
    v = '0;
    if (addr == ADDR_MODE) begin
      v = {11'd0, mode_r};
    end else if (addr == ADDR_STATUS) begin
      t = last_r;
      if (last_r == RT_GENERAL && backup_view) t = RT_BACKUP;
      v[10:8]     = t;
      v[SR_USER]  = usr_stat;
      v[SR_NRSTL] = pin && !power;
      v[SR_SRCMP] = busy;
      usr_stat    = 1'b0;
    end
    return v;
  endfunction

  function automatic void write_reg(logic [3:0] addr, logic [31:0] v, logic wp);
    if (addr == ADDR_CTRL) begin
      if ((v & KEY_MASK) != KEY_VALUE || busy || pend_r != RT_NONE) return;
      if (!v[CR_PROCRST] && !v[CR_EXTRST]) return;
      busy    = 1'b1;
      sw_proc = v[CR_PROCRST];
      int_cnt = INTERNAL_TICKS;
      if (v[CR_EXTRST]) drive_ext_reset();
      if (v[CR_PROCRST]) begin
        pend_r = RT_SOFTWARE;
        raise_request();
      end
    end else if (addr == ADDR_MODE) begin
      if ((v & KEY_MASK) != KEY_VALUE || wp) return;
      mode_r = v[20:0] & MR_MASK;
    end
  endfunction

  function automatic rc_out_t next_lines(rc_in_t it);
    rc_out_t r;
    r     = '0;
    pulse = 1'b0;
    case (it.op)
      OP_READ:      r.rdata = read_reg(it.addr);
      OP_WRITE:     write_reg(it.addr, it.wdata, it.write_protected);
      OP_PIN:       pin_change(it.level);
      OP_POWER:     power_change(it.level, it.system_in_reset);
      OP_WATCHDOG:  watchdog_change(it.level, it.system_in_reset);
      OP_TICK:      slow_tick();
      OP_COLD:      cold_restart();
      OP_WAKEUP:    wakeup_restart();
      OP_TAKE_WARM: begin
        r.warm_taken = warm;
        warm         = 1'b0;
      end
      default: ;
    endcase
    r.irq                = usr_stat && !mode_r[MR_URSTEN] && mode_r[MR_URSTIEN];
    r.ext_rst_n          = ext_lvl;
    r.core_reset_request = core_req;
    r.system_reset_pulse = pulse;
    r.gpbr_clear         = mode_r[MR_ENGCLR];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backup_view = 1'b0;
      pulse       = 1'b0;
      cold_restart();
      lines_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) backup_view = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (lines_due.size() == 0) begin
          log_fault($sformatf("unexpected result beat %h", out_data_i));
        end else begin
          want = lines_due.pop_front();
          check_field("rdata", want.rdata, out_data_i.rdata);
          check_field("irq", want.irq, out_data_i.irq);
          check_field("ext_rst_n", want.ext_rst_n, out_data_i.ext_rst_n);
          check_field("core_reset_request", want.core_reset_request,
                      out_data_i.core_reset_request);
          check_field("system_reset_pulse", want.system_reset_pulse,
                      out_data_i.system_reset_pulse);
          check_field("warm_taken", want.warm_taken, out_data_i.warm_taken);
          check_field("gpbr_clear", want.gpbr_clear, out_data_i.gpbr_clear);
        end
      end
      if (in_valid_i && !in_stall_i) lines_due.push_back(next_lines(in_data_i));
    end
    due_o    <= lines_due.size();
    faults_o <= fault_cnt;
  end

endmodule

[bench/reset_controller_unit_tb.sv]
`timescale 1ns / 1ps

module reset_controller_unit_tb;
  import rstc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  rc_in_t  in_data = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  rc_out_t out_data;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_data = 1'b0;

  int      faults;
  int      due;
  int      cycle_cnt = 0;
  int      items_sent = 0;
  int      stall_left = 0;
  logic    calm = 1'b0;

  reset_controller_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  reset_controller_check chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .faults_o    (faults),
    .due_o       (due)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side stalls in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic seldom();
    return $urandom_range(0, 3) == 0;
  endfunction

  function automatic logic [3:0] any_nibble();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [31:0] keyed(logic [31:0] w);
    logic [31:0] k;
    k = w;
    if ($urandom_range(0, 7) != 0) k[31:24] = KEY_VALUE[31:24];
    return k;
  endfunction

  function automatic logic [31:0] mode_word();
    logic [31:0] w;
    w = keyed($urandom);
    if ($urandom_range(0, 15) != 0) w[11:8] = 4'($urandom_range(0, 2));
    return w;
  endfunction

  task automatic send(logic [3:0] op, logic [3:0] addr, logic [31:0] wdata,
                      logic lvl, logic wp, logic inr);
    rc_in_t it;
    it.op              = op;
    it.addr            = addr;
    it.wdata           = wdata;
    it.level           = lvl;
    it.write_protected = wp;
    it.system_in_reset = inr;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic tick_burst(int n);
    repeat (n) send(OP_TICK, any_nibble(), $urandom, coin(), coin(), coin());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_mix(int count);
    int          stop_at;
    logic [3:0]  addr;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 15))
        0, 1: begin
          send(OP_PIN, any_nibble(), $urandom, 1'b0, coin(), seldom());
          tick_burst($urandom_range(0, 4));
          send(OP_PIN, any_nibble(), $urandom, 1'b1, coin(), seldom());
          tick_burst($urandom_range(0, 8));
        end
        2: send(OP_PIN, any_nibble(), $urandom, coin(), coin(), coin());
        3: begin
          send(OP_WATCHDOG, any_nibble(), $urandom, 1'b1, coin(), seldom());
          tick_burst($urandom_range(0, 5));
          send(OP_WATCHDOG, any_nibble(), $urandom, 1'b0, coin(), seldom());
        end
        4: begin
          send(OP_POWER, any_nibble(), $urandom, 1'b1, coin(), seldom());
          tick_burst($urandom_range(0, 3));
          if (coin()) send(OP_PIN, any_nibble(), $urandom, coin(), coin(), coin());
          send(OP_POWER, any_nibble(), $urandom, 1'b0, coin(), seldom());
          tick_burst($urandom_range(0, 2));
        end
        5, 6: begin
          send(OP_WRITE, ADDR_CTRL, keyed($urandom), coin(), coin(), coin());
          tick_burst($urandom_range(0, 5));
        end
        7: send(OP_WRITE, ADDR_MODE, mode_word(), coin(), seldom(), coin());
        8, 9: begin
          case ($urandom_range(0, 3))
            0: addr = ADDR_CTRL;
            1: addr = ADDR_MODE;
            2: addr = any_nibble();
            default: addr = ADDR_STATUS;
          endcase
          send(OP_READ, addr, $urandom, coin(), coin(), coin());
        end
        10: tick_burst($urandom_range(1, 10));
        11: send(OP_TAKE_WARM, any_nibble(), $urandom, coin(), coin(), coin());
        12: send(OP_WAKEUP, any_nibble(), $urandom, coin(), coin(), coin());
        13: begin
          if (seldom()) send(OP_COLD, any_nibble(), $urandom, coin(), coin(), coin());
          else tick_burst(1);
        end
        14: send(any_nibble(), any_nibble(), $urandom, coin(), coin(), coin());
        default: send(OP_WRITE, any_nibble(), keyed($urandom), coin(), coin(),
                      coin());
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(1'b0);

    send(OP_READ, ADDR_STATUS, '0, 1'b0, 1'b0, 1'b0);
    send(OP_READ, ADDR_MODE, '0, 1'b0, 1'b0, 1'b0);
    send(OP_READ, ADDR_CTRL, '0, 1'b0, 1'b0, 1'b0);
    send(OP_READ, 4'hf, 32'hffff_ffff, 1'b1, 1'b1, 1'b1);
    send(OP_WRITE, ADDR_MODE, 32'h5a10_0015, 1'b0, 1'b0, 1'b0);
    send(OP_WRITE, ADDR_MODE, KEY_VALUE | 32'h0010_0015, 1'b0, 1'b1, 1'b0);
    send(OP_WRITE, ADDR_MODE, KEY_VALUE | 32'h0010_0015, 1'b0, 1'b0, 1'b0);
    send(OP_WRITE, ADDR_STATUS, 32'hffff_ffff, 1'b0, 1'b0, 1'b0);
    send(OP_PIN, '0, '0, 1'b0, 1'b0, 1'b0);
    send(OP_TAKE_WARM, '0, '0, 1'b0, 1'b0, 1'b0);
    tick_burst(2);
    send(OP_PIN, '0, '0, 1'b1, 1'b0, 1'b0);
    tick_burst(6);
    send(OP_WRITE, ADDR_CTRL, KEY_VALUE | 32'h9, 1'b0, 1'b0, 1'b0);
    send(OP_WRITE, ADDR_CTRL, KEY_VALUE | 32'h9, 1'b0, 1'b0, 1'b0);
    tick_burst(3);
    send(OP_WATCHDOG, '0, '0, 1'b1, 1'b0, 1'b0);
    send(OP_WATCHDOG, '0, '0, 1'b0, 1'b0, 1'b0);
    send(OP_POWER, '0, '0, 1'b1, 1'b0, 1'b0);
    send(OP_POWER, '0, '0, 1'b0, 1'b0, 1'b0);
    send(OP_READ, ADDR_STATUS, '0, 1'b0, 1'b0, 1'b0);
    send(OP_WAKEUP, '0, '0, 1'b0, 1'b0, 1'b0);
    send(OP_WRITE, ADDR_MODE, KEY_VALUE | 32'h00ff_ffff, 1'b0, 1'b0, 1'b0);
    send(OP_READ, ADDR_MODE, '0, 1'b0, 1'b0, 1'b0);
    send(4'hf, 4'hf, 32'hffff_ffff, 1'b1, 1'b1, 1'b1);
    send(OP_COLD, '0, '0, 1'b0, 1'b0, 1'b0);

    write_cfg(1'b1);
    run_mix(450);
    write_cfg(1'b0);
    run_mix(450);
    write_cfg(coin());
    run_mix(400);
    write_cfg(1'b1);
    calm = 1'b1;
    run_mix(400);

    drain();
    repeat (8) @(posedge clk);
    if (faults == 0 && due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/rstc_pkg.sv
sv/reset_controller_unit.sv
bench/reset_controller_check.sv
bench/reset_controller_unit_tb.sv
